@@ rtl/core/drbm_pkg.sv @@
// ----------------------------------------------------------------------------
// drbm_pkg
// Shared constants and types for the DRAM bank/row address mapper.
// ----------------------------------------------------------------------------
package drbm_pkg;

  localparam int ADDR_BITS_DEF     = 48;
  localparam int MAX_FUNCTIONS_DEF = 5;

  // bank number field is fixed at five function bits
  localparam int BANK_BITS      = 5;
  localparam int FN_COUNT_BITS  = 3;
  localparam int REG_INDEX_BITS = 3;

  // register indexes
  localparam logic [REG_INDEX_BITS-1:0] REG_MASK_A       = 3'd0;
  localparam logic [REG_INDEX_BITS-1:0] REG_MASK_B       = 3'd1;
  localparam logic [REG_INDEX_BITS-1:0] REG_MASK_C       = 3'd2;
  localparam logic [REG_INDEX_BITS-1:0] REG_MASK_D       = 3'd3;
  localparam logic [REG_INDEX_BITS-1:0] REG_MASK_E       = 3'd4;
  localparam logic [REG_INDEX_BITS-1:0] REG_FUNCS_IN_USE = 3'd5;
  localparam logic [REG_INDEX_BITS-1:0] REG_ROW_MASK     = 3'd6;
  localparam logic [REG_INDEX_BITS-1:0] REG_BANK_GOAL    = 3'd7;

  // per-stage function control, driven from the configuration registers
  typedef struct packed {
    logic active;
    logic want;
  } stage_ctrl_t;

endpackage

@@ rtl/core/drbm_func_stage.sv @@
// ----------------------------------------------------------------------------
// drbm_func_stage
// One pipeline stage: evaluates one bank function on the original and the
// running rebased address, and flips the mask's lowest bit where needed.
// ----------------------------------------------------------------------------
module drbm_func_stage #(
  parameter int ADDR_BITS  = drbm_pkg::ADDR_BITS_DEF,
  parameter int FUNC_INDEX = 0
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  input  logic [ADDR_BITS-1:0]           in_addr,
  input  logic [ADDR_BITS-1:0]           in_moved,
  input  logic [drbm_pkg::BANK_BITS-1:0] in_bank,
  input  logic [ADDR_BITS-1:0]           func_mask,
  input  drbm_pkg::stage_ctrl_t          ctrl,
  output logic                           out_valid,
  output logic [ADDR_BITS-1:0]           out_addr,
  output logic [ADDR_BITS-1:0]           out_moved,
  output logic [drbm_pkg::BANK_BITS-1:0] out_bank
);

  logic [ADDR_BITS-1:0]           addr_sel;
  logic [ADDR_BITS-1:0]           moved_sel;
  logic [ADDR_BITS-1:0]           mask_low;
  logic                           addr_fbit;
  logic                           moved_fbit;
  logic [ADDR_BITS-1:0]           moved_next;
  logic [drbm_pkg::BANK_BITS-1:0] bank_next;

  always_comb begin
    addr_sel   = in_addr & func_mask;
    moved_sel  = in_moved & func_mask;
    // bit is 0 when the selected bits are all clear or all set
    addr_fbit  = !((addr_sel == '0) || (addr_sel == func_mask));
    moved_fbit = !((moved_sel == '0) || (moved_sel == func_mask));
    mask_low   = func_mask & (~func_mask + ADDR_BITS'(1));

    moved_next = in_moved;
    if (ctrl.active && (moved_fbit != ctrl.want)) begin
      moved_next = in_moved ^ mask_low;
    end

    bank_next = in_bank;
    if (ctrl.active) begin
      bank_next[FUNC_INDEX] = addr_fbit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_addr  <= in_addr;
    out_moved <= moved_next;
    out_bank  <= bank_next;
  end

endmodule

@@ rtl/core/dram_bank_row_address_mapper.sv @@
// A started address moves through the registered stages and is flagged by done.
// Throughput: one address per cycle; results are strobed on done, no back-pressure.
// Depth follows the rebasing chain; each function stage evaluates one function.
// Reset (rst, synchronous) clears all configuration registers to zero and
// drops every transaction in flight; busy is high only while rst is high.
// ----------------------------------------------------------------------------
// dram_bank_row_address_mapper
// Classifies an address into bank functions, rebases it into a target
// bank and extracts the row index.
// ----------------------------------------------------------------------------
module dram_bank_row_address_mapper #(
  parameter int ADDR_BITS     = drbm_pkg::ADDR_BITS_DEF,
  parameter int MAX_FUNCTIONS = drbm_pkg::MAX_FUNCTIONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ADDR_BITS-1:0]                address,
  output logic                                done,
  output logic [drbm_pkg::BANK_BITS-1:0]      bank_bits,
  output logic [ADDR_BITS-1:0]                rebased_address,
  output logic [ADDR_BITS-1:0]                row_index,
  input  logic                                wr_en,
  input  logic [drbm_pkg::REG_INDEX_BITS-1:0] wr_index,
  input  logic [ADDR_BITS-1:0]                wr_data
);

  localparam int NUM_STAGES = (MAX_FUNCTIONS > 3) ? MAX_FUNCTIONS : 3;
  localparam int SHIFT_BITS = $clog2(ADDR_BITS);

  // configuration
  logic [ADDR_BITS-1:0]                   function_mask [MAX_FUNCTIONS];
  logic [drbm_pkg::FN_COUNT_BITS-1:0]     functions_in_use;
  logic [ADDR_BITS-1:0]                   row_mask;
  logic [drbm_pkg::BANK_BITS-1:0]         bank_goal;

  logic accepted;

  logic                           stage_valid [NUM_STAGES];
  logic [ADDR_BITS-1:0]           stage_addr  [NUM_STAGES];
  logic [ADDR_BITS-1:0]           stage_moved [NUM_STAGES];
  logic [drbm_pkg::BANK_BITS-1:0] stage_bank  [NUM_STAGES];
  logic [ADDR_BITS-1:0]           stage_row   [NUM_STAGES];

  logic [ADDR_BITS-1:0]  row_low;
  logic [SHIFT_BITS-1:0] row_shift_next;
  logic [SHIFT_BITS-1:0] row_shift;

  assign busy     = rst;
  assign accepted = start && !busy;

  // ---- configuration writes ----
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_FUNCTIONS; j++) begin
        function_mask[j] <= '0;
      end
      functions_in_use <= '0;
      row_mask         <= '0;
      bank_goal        <= '0;
    end else if (wr_en) begin
      for (int j = 0; j < MAX_FUNCTIONS; j++) begin
        if (wr_index == drbm_pkg::REG_INDEX_BITS'(j)) begin
          function_mask[j] <= wr_data;
        end
      end
      unique case (wr_index)
        drbm_pkg::REG_MASK_A, drbm_pkg::REG_MASK_B, drbm_pkg::REG_MASK_C,
        drbm_pkg::REG_MASK_D, drbm_pkg::REG_MASK_E: begin
          // handled above, masks beyond MAX_FUNCTIONS are never used
        end
        drbm_pkg::REG_FUNCS_IN_USE: begin
          functions_in_use <= wr_data[drbm_pkg::FN_COUNT_BITS-1:0];
        end
        drbm_pkg::REG_ROW_MASK: begin
          row_mask <= wr_data;
        end
        drbm_pkg::REG_BANK_GOAL: begin
          bank_goal <= wr_data[drbm_pkg::BANK_BITS-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---- bank function stages ----
  for (genvar j = 0; j < NUM_STAGES; j++) begin : g_stage
    logic [ADDR_BITS-1:0]           s_mask;
    drbm_pkg::stage_ctrl_t          s_ctrl;
    logic                           s_in_valid;
    logic [ADDR_BITS-1:0]           s_in_addr;
    logic [ADDR_BITS-1:0]           s_in_moved;
    logic [drbm_pkg::BANK_BITS-1:0] s_in_bank;

    if (j < MAX_FUNCTIONS) begin : g_fn
      // comparing against the raw count saturates it at MAX_FUNCTIONS for free
      assign s_mask      = function_mask[j];
      assign s_ctrl.active = (functions_in_use > drbm_pkg::FN_COUNT_BITS'(j));
      assign s_ctrl.want   = bank_goal[j];
    end else begin : g_pass
      assign s_mask        = '0;
      assign s_ctrl.active = 1'b0;
      assign s_ctrl.want   = 1'b0;
    end

    if (j == 0) begin : g_first
      assign s_in_valid = accepted;
      assign s_in_addr  = address;
      assign s_in_moved = address;
      assign s_in_bank  = '0;
    end else begin : g_next
      assign s_in_valid = stage_valid[j-1];
      assign s_in_addr  = stage_addr[j-1];
      assign s_in_moved = stage_moved[j-1];
      assign s_in_bank  = stage_bank[j-1];
    end

    drbm_func_stage #(
      .ADDR_BITS  (ADDR_BITS),
      .FUNC_INDEX (j)
    ) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (s_in_valid),
      .in_addr   (s_in_addr),
      .in_moved  (s_in_moved),
      .in_bank   (s_in_bank),
      .func_mask (s_mask),
      .ctrl      (s_ctrl),
      .out_valid (stage_valid[j]),
      .out_addr  (stage_addr[j]),
      .out_moved (stage_moved[j]),
      .out_bank  (stage_bank[j])
    );
  end

  // ---- row index: encode the shift in stage 0, shift in stage 1 ----
  always_comb begin
    row_low        = row_mask & (~row_mask + ADDR_BITS'(1));
    row_shift_next = '0;
    for (int i = 0; i < ADDR_BITS; i++) begin
      if (row_low[i]) begin
        row_shift_next = row_shift_next | SHIFT_BITS'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    stage_row[0] <= address & row_mask;
    row_shift    <= row_shift_next;
    stage_row[1] <= stage_row[0] >> row_shift;
    for (int j = 2; j < NUM_STAGES; j++) begin
      stage_row[j] <= stage_row[j-1];
    end
  end

  assign done            = stage_valid[NUM_STAGES-1];
  assign bank_bits       = stage_bank[NUM_STAGES-1];
  assign rebased_address = stage_moved[NUM_STAGES-1];
  assign row_index       = stage_row[NUM_STAGES-1];

  // ---- assertions ----
  a_accept_reaches_output: assert property (@(posedge clk) disable iff (rst)
    accepted |-> ##NUM_STAGES done)
    else $error("accepted transaction did not reach the output");

  a_no_spurious_result: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accepted, NUM_STAGES))
    else $error("result without a matching transaction");

  a_unused_bank_bits_clear: assert property (@(posedge clk) disable iff (rst)
    done |-> ((bank_bits >> MAX_FUNCTIONS) == '0))
    else $error("bank bit set beyond the supported functions");

endmodule
